@@ rtl/core/adc_button_range_table_macros.svh @@
// Assertion macros for the ADC button range table.
`ifndef ADC_BUTTON_RANGE_TABLE_MACROS_SVH
`define ADC_BUTTON_RANGE_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
`define ABRT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ABRT_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ABRT_ASSERT(label, clk, rst_n, prop, msg)
`define ABRT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ rtl/core/abrt_pkg.sv @@
// Shared types and constants of the ADC button range table.
package abrt_pkg;
  localparam int RANGE_SLOTS = 16;
  localparam int BUTTONS_PER_RANGE = 4;
  localparam int BUTTON_CODES = 32;
  localparam int MV_W = 16;
  localparam int CODE_W = $clog2(BUTTON_CODES);
  localparam int CNT_W = $clog2(BUTTONS_PER_RANGE + 1);
  localparam int SLOT_W = $clog2(RANGE_SLOTS);
  localparam int RCNT_W = $clog2(RANGE_SLOTS + 1);
  localparam int BIDX_W = (BUTTONS_PER_RANGE > 1) ? $clog2(BUTTONS_PER_RANGE) : 1;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_INVALID   = 3'd3,
    ST_LIST_FULL = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_EMIT
  } fsm_t;

  typedef struct packed {
    logic [MV_W-1:0]   lower;
    logic [MV_W-1:0]   upper;
    logic [CNT_W-1:0]  count;
    logic [BUTTONS_PER_RANGE-1:0][CODE_W-1:0] codes;
  } slot_t;

  // Per-cycle command from the controller to every cell.
  typedef struct packed {
    logic clear;       // empty all cells
    logic rotate;      // every cell takes its upper neighbor's content
    logic shift_in;    // cells above ins_pos take lower neighbor (open gap)
    logic write_new;   // cell at ins_pos takes the new range
    logic add_btn;     // cell at ins_pos appends a button code
    logic [SLOT_W-1:0] ins_pos;
    logic [MV_W-1:0]   lower;
    logic [MV_W-1:0]   upper;
    logic [CODE_W-1:0] code;
  } cell_cmd_t;
endpackage

@@ rtl/core/abrt_cell.sv @@
// One slot of the range table: holds a range and passes it to its neighbors.
module abrt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [abrt_pkg::SLOT_W-1:0] idx,
  input  abrt_pkg::cell_cmd_t cmd,
  input  abrt_pkg::slot_t    from_up,
  input  abrt_pkg::slot_t    from_down,
  output abrt_pkg::slot_t    q
);
  import abrt_pkg::*;

  logic [MV_W-1:0]  lower_r, lower_nxt, upper_r, upper_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [BUTTONS_PER_RANGE-1:0][CODE_W-1:0] codes_r, codes_nxt;

  // Select the next content of this slot
  always_comb begin
    lower_nxt = lower_r;
    upper_nxt = upper_r;
    count_nxt = count_r;
    codes_nxt = codes_r;
    if (cmd.rotate) begin
      lower_nxt = from_up.lower;
      upper_nxt = from_up.upper;
      count_nxt = from_up.count;
      codes_nxt = from_up.codes;
    end else if (cmd.write_new && idx == cmd.ins_pos) begin
      lower_nxt = cmd.lower;
      upper_nxt = cmd.upper;
      count_nxt = CNT_W'(1);
      codes_nxt[0] = cmd.code;
    end else if (cmd.shift_in && idx > cmd.ins_pos) begin
      lower_nxt = from_down.lower;
      upper_nxt = from_down.upper;
      count_nxt = from_down.count;
      codes_nxt = from_down.codes;
    end else if (cmd.add_btn && idx == cmd.ins_pos) begin
      codes_nxt[count_r[BIDX_W-1:0]] = cmd.code;
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // Count is control state; limits and codes are payload
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    lower_r <= lower_nxt;
    upper_r <= upper_nxt;
    codes_r <= codes_nxt;
  end

  assign q = '{lower: lower_r, upper: upper_r, count: count_r, codes: codes_r};
endmodule

@@ rtl/core/abrt_ctrl.sv @@
// Sequencer: scans the rotating cell chain, decides, and emits results.
module abrt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [55:0]         in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [47:0]         out_tdata,
  output logic                out_tlast,
  input  abrt_pkg::slot_t     head,
  output abrt_pkg::cell_cmd_t cmd,
  output logic                busy
);
  import abrt_pkg::*;

  fsm_t state_r, state_nxt;
  action_t act_r, act_nxt;
  logic [MV_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, smp_r, smp_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [RCNT_W-1:0] rcnt_r, rcnt_nxt, step_r, step_nxt;
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic hit_r, hit_nxt, pos_set_r, pos_set_nxt, ovl_r, ovl_nxt;
  logic [MV_W-1:0] prev_up_r, prev_up_nxt;
  slot_t hit_slot_r, hit_slot_nxt;
  logic [CNT_W-1:0] emit_r, emit_nxt;
  logic ovl_chk_r, ovl_chk_nxt;
  logic ov_r, ov_nxt;
  status_t st_r, st_nxt;
  logic last_r, last_nxt;
  logic [CODE_W-1:0] btn_r, btn_nxt;
  logic [MV_W-1:0] olo_r, olo_nxt, ohi_r, ohi_nxt;
  logic [CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic [SLOT_W-1:0] opos_r, opos_nxt;
  logic ovalid_r, ovalid_nxt;
  logic in_ok, out_ok, in_slot;

  assign in_ok  = in_tvalid && in_tready;
  assign out_ok = out_tvalid && out_tready;
  assign in_slot = step_r < rcnt_r;
  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign busy = state_r != S_IDLE;

  // Next state, scan bookkeeping and cell commands
  always_comb begin
    state_nxt = state_r; act_nxt = act_r; lo_nxt = lo_r; hi_nxt = hi_r;
    smp_nxt = smp_r; code_nxt = code_r; rcnt_nxt = rcnt_r; step_nxt = step_r;
    pos_nxt = pos_r; hit_nxt = hit_r; pos_set_nxt = pos_set_r; ovl_nxt = ovl_r;
    prev_up_nxt = prev_up_r; hit_slot_nxt = hit_slot_r; emit_nxt = emit_r;
    ovl_chk_nxt = ovl_chk_r; ov_nxt = ov_r;
    st_nxt = st_r; last_nxt = last_r; btn_nxt = btn_r; olo_nxt = olo_r;
    ohi_nxt = ohi_r; ocnt_nxt = ocnt_r; opos_nxt = opos_r;
    ovalid_nxt = ovalid_r && !out_tready;
    cmd = '0;
    cmd.ins_pos = pos_r; cmd.lower = lo_r; cmd.upper = hi_r; cmd.code = code_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ok) begin
          act_nxt = action_t'(in_tdata[1:0]);
          lo_nxt = in_tdata[17:2];
          hi_nxt = in_tdata[33:18];
          code_nxt = in_tdata[38:34];
          smp_nxt = in_tdata[54:39];
          step_nxt = '0; hit_nxt = 1'b0; pos_set_nxt = 1'b0;
          pos_nxt = '0; ovl_nxt = 1'b0; ovl_chk_nxt = 1'b0;
          unique case (action_t'(in_tdata[1:0]))
            ACT_CLEAR: begin
              cmd.clear = 1'b1; rcnt_nxt = '0;
              st_nxt = ST_OK; ov_nxt = 1'b0; btn_nxt = '0; olo_nxt = '0;
              ohi_nxt = '0; ocnt_nxt = '0; opos_nxt = '0; last_nxt = 1'b1;
              ovalid_nxt = 1'b1;
            end
            ACT_INSERT, ACT_LOOKUP: state_nxt = S_SCAN;
            default: ;
          endcase
        end
      end
      // Rotate the whole chain once; head shows slot step_r
      S_SCAN: begin
        cmd.rotate = 1'b1;
        if (in_slot) begin
          if (act_r == ACT_LOOKUP) begin
            if (!hit_r && smp_r >= head.lower && smp_r <= head.upper) begin
              hit_nxt = 1'b1; hit_slot_nxt = head; pos_nxt = step_r[SLOT_W-1:0];
            end
          end else if (!ovl_chk_r) begin
            if (!hit_r && head.lower == lo_r && head.upper == hi_r) begin
              hit_nxt = 1'b1; hit_slot_nxt = head; pos_nxt = step_r[SLOT_W-1:0];
            end
            if (!pos_set_r && !(head.lower <= lo_r) && !hit_r) begin
              pos_set_nxt = 1'b1;
              if (!(head.lower == lo_r && head.upper == hi_r))
                pos_nxt = step_r[SLOT_W-1:0];
            end
          end else begin
            if (step_r != '0 && prev_up_r >= head.lower) ovl_nxt = 1'b1;
          end
          prev_up_nxt = head.upper;
        end
        step_nxt = step_r + RCNT_W'(1);
        if (step_r == RCNT_W'(RANGE_SLOTS - 1)) begin
          step_nxt = '0;
          state_nxt = ovl_chk_r ? S_EMIT : S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (act_r == ACT_LOOKUP) begin
          emit_nxt = '0;
          state_nxt = S_EMIT;
        end else if (hit_r) begin
          if (hit_slot_r.count >= CNT_W'(BUTTONS_PER_RANGE)) begin
            st_nxt = ST_LIST_FULL; ov_nxt = 1'b0; btn_nxt = '0; olo_nxt = lo_r;
            ohi_nxt = hi_r; ocnt_nxt = hit_slot_r.count; opos_nxt = pos_r;
            last_nxt = 1'b1; ovalid_nxt = 1'b1; state_nxt = S_IDLE;
          end else begin
            cmd.add_btn = 1'b1;
            ocnt_nxt = hit_slot_r.count + CNT_W'(1);
            ovl_chk_nxt = 1'b1; state_nxt = S_SCAN;
          end
        end else if (rcnt_r >= RCNT_W'(RANGE_SLOTS)) begin
          st_nxt = ST_FULL; ov_nxt = 1'b0; btn_nxt = '0; olo_nxt = '0; ohi_nxt = '0;
          ocnt_nxt = '0; opos_nxt = '0; last_nxt = 1'b1; ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (lo_r > hi_r) begin
          st_nxt = ST_INVALID; ov_nxt = 1'b0; btn_nxt = '0; olo_nxt = '0; ohi_nxt = '0;
          ocnt_nxt = '0; opos_nxt = '0; last_nxt = 1'b1; ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          if (!pos_set_r) pos_nxt = rcnt_r[SLOT_W-1:0];
          state_nxt = S_SHIFT;
        end
      end
      // Open the gap and drop the new range in
      S_SHIFT: begin
        cmd.shift_in = 1'b1; cmd.write_new = 1'b1;
        rcnt_nxt = rcnt_r + RCNT_W'(1);
        ocnt_nxt = CNT_W'(1);
        ovl_chk_nxt = 1'b1; state_nxt = S_SCAN;
      end
      S_EMIT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1; ov_nxt = 1'b0;
          if (ovl_chk_r) begin
            st_nxt = ST_OK; ov_nxt = ovl_r; btn_nxt = '0; olo_nxt = lo_r;
            ohi_nxt = hi_r; opos_nxt = pos_r; last_nxt = 1'b1; state_nxt = S_IDLE;
          end else if (!hit_r) begin
            st_nxt = ST_NOT_FOUND; btn_nxt = '0; olo_nxt = '0; ohi_nxt = '0;
            ocnt_nxt = '0; opos_nxt = '0; last_nxt = 1'b1; state_nxt = S_IDLE;
          end else begin
            st_nxt = ST_OK; olo_nxt = hit_slot_r.lower; ohi_nxt = hit_slot_r.upper;
            ocnt_nxt = hit_slot_r.count; opos_nxt = pos_r;
            btn_nxt = (hit_slot_r.count == '0) ? '0
                      : hit_slot_r.codes[emit_r[BIDX_W-1:0]];
            emit_nxt = emit_r + CNT_W'(1);
            last_nxt = (hit_slot_r.count == '0) ||
                       (emit_r + CNT_W'(1) >= hit_slot_r.count);
            if (last_nxt) state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ovalid_r <= 1'b0; rcnt_r <= '0;
    end else begin
      state_r <= state_nxt; ovalid_r <= ovalid_nxt; rcnt_r <= rcnt_nxt;
    end
    act_r <= act_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; smp_r <= smp_nxt;
    code_r <= code_nxt; step_r <= step_nxt; pos_r <= pos_nxt; hit_r <= hit_nxt;
    pos_set_r <= pos_set_nxt; ovl_r <= ovl_nxt; prev_up_r <= prev_up_nxt;
    hit_slot_r <= hit_slot_nxt; emit_r <= emit_nxt; ovl_chk_r <= ovl_chk_nxt;
    ov_r <= ov_nxt; st_r <= st_nxt; last_r <= last_nxt; btn_r <= btn_nxt;
    olo_r <= olo_nxt; ohi_r <= ohi_nxt; ocnt_r <= ocnt_nxt; opos_r <= opos_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {opos_r, ocnt_r, ohi_r, olo_r, btn_r, ov_r, st_r};
endmodule

@@ rtl/core/adc_button_range_table.sv @@
// Top level: ADC button range table, a chain of slot cells and its sequencer.
// Input stream in_*: one transaction per command (clear, insert, lookup).
// Output stream out_*: result transactions; out_tlast marks the last one of a
// command. Clear answers in the cycle after it is accepted. Insert takes one
// full rotation of the 16-cell chain to match and place, a decision step, a
// shift step when a new range opens, and a second rotation for the neighbor
// overlap check; a rejected insert answers after the decision step. Lookup
// takes one rotation plus a decision step, then emits one result per button
// code of the matching range, or a single not-found result. The chain rotates
// one slot per cycle past the head cell. An unused action code is dropped with
// no result. Reset empties the table (all button counts and the range count
// are zero); limits and codes are left as they are. When the receiver stalls
// the result register holds and the block takes no new command until the last
// result of the current one has been taken.
`include "adc_button_range_table_macros.svh"
module adc_button_range_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // action[1:0], lower_mv[17:2], upper_mv[33:18], button_code[38:34],
  // sample_mv[54:39], zero fill
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], overlap[3], found_button[8:4], range_low[24:9],
  // range_high[40:25], button_count[43:41], position[47:44]
  output logic [47:0] out_tdata,
  output logic        out_tlast
);
  import abrt_pkg::*;

  slot_t q [RANGE_SLOTS];
  cell_cmd_t cmd;
  logic busy;

  // Cell chain: rotation moves each slot one place toward the head
  for (genvar g = 0; g < RANGE_SLOTS; g++) begin : g_cell
    abrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (SLOT_W'(g)),
      .cmd       (cmd),
      .from_up   (q[(g + 1) % RANGE_SLOTS]),
      .from_down (q[(g + RANGE_SLOTS - 1) % RANGE_SLOTS]),
      .q         (q[g])
    );
  end

  abrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .head       (q[0]),
    .cmd        (cmd),
    .busy       (busy)
  );

  `ABRT_ASSERT(a_no_accept_busy, clk, rst_n, busy |-> !in_tready, "accept while busy")
  `ABRT_ASSERT(a_cmd_excl, clk, rst_n, $onehot0({cmd.rotate, cmd.add_btn, cmd.clear}), "cmd clash")
  `ABRT_ASSERT(a_status_range, clk, rst_n, out_tvalid |-> out_tdata[2:0] <= 3'd4, "bad status")
  `ABRT_ASSERT_NR(a_reset_idle, clk, !rst_n |=> !out_tvalid, "valid after reset")
endmodule
